[rtl/qcs_pkg.sv]
`default_nettype none

package qcs_pkg;

  // Slot and ID limits of the steering table.
  localparam int unsigned SOCKET_SLOTS  = 256;
  localparam logic [7:0]  MAX_ID_LENGTH = 8'd20;

  // 32-bit FNV-1a.
  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;

  localparam int unsigned HASH_STAGES = 4;  // one ID byte per stage
  localparam int unsigned MOD_STAGES  = 4;  // eight dividend bits per stage
  localparam int unsigned MOD_BITS    = 8;

  // Configuration register indexes.
  localparam logic REG_WORKER_COUNT     = 1'b0;
  localparam logic REG_SOURCE_ID_LENGTH = 1'b1;

  localparam logic VERDICT_PASS = 1'b0;
  localparam logic VERDICT_DROP = 1'b1;

  typedef enum logic [1:0] {
    RULE_FLOW  = 2'd0,
    RULE_LONG  = 2'd1,
    RULE_SHORT = 2'd2
  } rule_e;

  // Payload of the hash stages.
  typedef struct packed {
    logic [31:0] hash;
    logic [3:0]  hash_en;     // bit 0 applies in the current stage
    logic [31:0] ids;         // bits 7:0 hold the byte of the current stage
    logic [31:0] flow_hash;
    logic [7:0]  byte1;
    rule_e       rule;
    logic        no_workers;
  } hash_t;

  // Payload of the remainder stages.
  typedef struct packed {
    logic [31:0] num;         // dividend, unconsumed bits at the top
    logic [8:0]  rem;
    rule_e       rule;
    logic        no_workers;
  } mod_t;

endpackage

`default_nettype wire

[rtl/qcs_if.sv]
`default_nettype none

interface qcs_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  header_byte0;
  logic [7:0]  header_byte1;
  logic [7:0]  dest_id_length;
  logic [31:0] dest_id_bytes;
  logic [15:0] packet_length;
  logic [31:0] flow_hash;

  modport source (
    output valid, header_byte0, header_byte1, dest_id_length, dest_id_bytes,
           packet_length, flow_hash,
    input  ready
  );
  modport sink (
    input  valid, header_byte0, header_byte1, dest_id_length, dest_id_bytes,
           packet_length, flow_hash,
    output ready
  );
endinterface

interface qcs_dec_if;
  logic       valid;
  logic       ready;
  logic [7:0] worker_index;
  logic       verdict;
  logic [1:0] rule_used;

  modport source (
    output valid, worker_index, verdict, rule_used,
    input  ready
  );
  modport sink (
    input  valid, worker_index, verdict, rule_used,
    output ready
  );
endinterface

`default_nettype wire

[rtl/qcs_fnv_step.sv]
`default_nettype none

module qcs_fnv_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire qcs_pkg::hash_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output qcs_pkg::hash_t     data_o
);
  import qcs_pkg::*;

  logic  valid_q;
  hash_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Fold in the low ID byte when enabled, then shift the next byte down.
  always_comb begin
    data_d         = data_i;
    data_d.ids     = {8'd0, data_i.ids[31:8]};
    data_d.hash_en = {1'b0, data_i.hash_en[3:1]};
    if (data_i.hash_en[0]) begin
      data_d.hash = (data_i.hash ^ {24'd0, data_i.ids[7:0]}) * FNV_PRIME;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/qcs_mod_step.sv]
`default_nettype none

module qcs_mod_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [8:0]    divisor_i,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire qcs_pkg::mod_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output qcs_pkg::mod_t      data_o
);
  import qcs_pkg::*;

  logic valid_q;
  mod_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Restoring remainder, one dividend bit per step.
  always_comb begin
    logic [9:0]  r;
    logic [31:0] n;
    r = {1'b0, data_i.rem};
    n = data_i.num;
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[8:0], n[31]};
      n = {n[30:0], 1'b0};
      if (r >= {1'b0, divisor_i}) begin
        r = r - {1'b0, divisor_i};
      end
    end
    data_d     = data_i;
    data_d.num = n;
    data_d.rem = r[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // A stalled stage holds its item.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(data_q))
    else $error("remainder stage lost or changed a stalled item");

  // An empty stage never blocks its upstream neighbor.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |-> ready_o)
    else $error("empty remainder stage not ready");

  // The consumed dividend bits leave zeros behind.
  a_num_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o && valid_i |=> data_q.num[MOD_BITS-1:0] == '0)
    else $error("dividend not shifted");

endmodule

`default_nettype wire

[rtl/quic_cid_worker_steer_core.sv]
`default_nettype none

// Channel   | Dir | Handshake     | Payload
// ----------+-----+---------------+---------------------------------------------------
// pkt_i     | in  | valid / ready | header bytes 0 and 1, dest ID length and bytes,
//           |     |               | packet length, flow hash
// dec_o     | out | valid / ready | worker_index, verdict, rule_used
// cfg_*_i   | in  | write enable  | worker count (index 0), source_id_length (index 1)
//
// One packet enters per cycle while dec_o is not stalled; its decision leaves after
// four FNV-1a stages (one ID byte each) and four remainder stages (eight bits each).
// Every stage has its own valid bit and takes a new item when it is empty or
// its output moves on, so a stall on dec_o holds items in place and bubbles
// collapse. Reset empties the pipeline and clears both configuration registers.
module quic_cid_worker_steer_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qcs_pkt_if.sink    pkt_i,
  qcs_dec_if.source  dec_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [8:0]  cfg_wdata_i
);
  import qcs_pkg::*;

  logic [8:0] num_workers_q;
  logic [7:0] source_id_length_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_workers_q      <= '0;
      source_id_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WORKER_COUNT:     num_workers_q      <= cfg_wdata_i;
        REG_SOURCE_ID_LENGTH: source_id_length_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Header decode: pick the rule and the ID bytes that enter the hash.
  // ---------------------------------------------------------------------------
  logic  long_ok, short_ok, no_workers;
  logic [3:0] hash_en;
  hash_t hash_in;

  always_comb begin
    no_workers = (num_workers_q == '0);
    // Long header needs 7 bytes and a dest ID length of 1 to 20.
    long_ok = pkt_i.header_byte0[7] && (pkt_i.packet_length >= 16'd7) &&
              (pkt_i.dest_id_length != 8'd0) &&
              (pkt_i.dest_id_length <= MAX_ID_LENGTH);
    // Short header needs a valid configured ID length and 2 bytes.
    short_ok = !pkt_i.header_byte0[7] && (pkt_i.packet_length >= 16'd2) &&
               (source_id_length_q != 8'd0) &&
               (source_id_length_q <= MAX_ID_LENGTH);
    // Each further byte must be inside both the ID and the packet.
    hash_en[0] = long_ok;
    hash_en[1] = long_ok && (pkt_i.dest_id_length > 8'd1) &&
                 (pkt_i.packet_length >= 16'd8);
    hash_en[2] = long_ok && (pkt_i.dest_id_length > 8'd2) &&
                 (pkt_i.packet_length >= 16'd9);
    hash_en[3] = long_ok && (pkt_i.dest_id_length > 8'd3) &&
                 (pkt_i.packet_length >= 16'd10);

    hash_in.hash       = FNV_OFFSET;
    hash_in.hash_en    = hash_en;
    hash_in.ids        = pkt_i.dest_id_bytes;
    hash_in.flow_hash  = pkt_i.flow_hash;
    hash_in.byte1      = pkt_i.header_byte1;
    hash_in.no_workers = no_workers;
    if (no_workers) begin
      hash_in.rule = RULE_FLOW;
    end else if (long_ok) begin
      hash_in.rule = RULE_LONG;
    end else if (short_ok) begin
      hash_in.rule = RULE_SHORT;
    end else begin
      hash_in.rule = RULE_FLOW;
    end
  end

  // ---------------------------------------------------------------------------
  // FNV-1a stages.
  // ---------------------------------------------------------------------------
  logic  [HASH_STAGES:0] hv, hr;
  hash_t                 hd [HASH_STAGES+1];

  assign hv[0]       = pkt_i.valid;
  assign hd[0]       = hash_in;
  assign pkt_i.ready = hr[0];

  for (genvar k = 0; k < HASH_STAGES; k++) begin : g_hash
    qcs_fnv_step u_fnv (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (hv[k]),
      .ready_o (hr[k]),
      .data_i  (hd[k]),
      .valid_o (hv[k+1]),
      .ready_i (hr[k+1]),
      .data_o  (hd[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Remainder stages: the chosen key modulo the worker count.
  // ---------------------------------------------------------------------------
  logic [MOD_STAGES:0] mv, mr;
  mod_t                md [MOD_STAGES+1];
  mod_t                mod_in;

  always_comb begin
    case (hd[HASH_STAGES].rule)
      RULE_LONG:  mod_in.num = hd[HASH_STAGES].hash;
      RULE_SHORT: mod_in.num = {24'd0, hd[HASH_STAGES].byte1};
      default:    mod_in.num = hd[HASH_STAGES].flow_hash;
    endcase
    mod_in.rem        = '0;
    mod_in.rule       = hd[HASH_STAGES].rule;
    mod_in.no_workers = hd[HASH_STAGES].no_workers;
  end

  assign mv[0]           = hv[HASH_STAGES];
  assign md[0]           = mod_in;
  assign hr[HASH_STAGES] = mr[0];

  for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
    qcs_mod_step u_mod (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (num_workers_q),
      .valid_i   (mv[k]),
      .ready_o   (mr[k]),
      .data_i    (md[k]),
      .valid_o   (mv[k+1]),
      .ready_i   (mr[k+1]),
      .data_o    (md[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Verdict: drop on zero workers or an index outside the socket slots.
  // ---------------------------------------------------------------------------
  logic [8:0] sel;
  logic       drop;

  assign sel  = md[MOD_STAGES].rem;
  assign drop = md[MOD_STAGES].no_workers || sel[8] ||
                ({4'd0, sel} >= 13'(SOCKET_SLOTS));

  assign dec_o.valid        = mv[MOD_STAGES];
  assign mr[MOD_STAGES]     = dec_o.ready;
  assign dec_o.verdict      = drop ? VERDICT_DROP : VERDICT_PASS;
  assign dec_o.worker_index = drop ? 8'd0 : sel[7:0];
  assign dec_o.rule_used    = md[MOD_STAGES].rule;

  // A dropped packet always reports index zero.
  a_drop_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && dec_o.verdict == VERDICT_DROP |-> dec_o.worker_index == 8'd0)
    else $error("dropped packet carries a worker index");

  // With no workers every accepted packet leaves as a flow-rule drop.
  a_no_workers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && md[MOD_STAGES].no_workers |->
      dec_o.verdict == VERDICT_DROP && dec_o.rule_used == RULE_FLOW)
    else $error("zero-worker packet not dropped on the flow rule");

  // A passed index lies inside the socket slots.
  a_pass_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && dec_o.verdict == VERDICT_PASS |->
      {5'd0, dec_o.worker_index} < 13'(SOCKET_SLOTS))
    else $error("passed index outside socket slots");

  // The rule code is one of the three defined rules.
  a_rule_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid |-> dec_o.rule_used == RULE_FLOW ||
                    dec_o.rule_used == RULE_LONG ||
                    dec_o.rule_used == RULE_SHORT)
    else $error("undefined rule code on output");

endmodule

`default_nettype wire
